// ===== src/vnr_pkg.sv =====
// Shared constants and codes for the view-to-normal frame rotation block.
package vnr_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	// Fractional bits of the cosine/sine ratios.
	localparam int FRAC = 30;
	// Unsigned quotient width: ratios reach exactly 1.0.
	localparam int QUO_W = FRAC + 1;
	// Signed ratio width.
	localparam int RATIO_W = QUO_W + 1;
	// Entries of the queue between front and back; power of two.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		CASE_VALID = 2'd0,
		CASE_AWAY  = 2'd1,
		CASE_BELOW = 2'd2
	} case_code_t;

	typedef enum logic [1:0] {
		REG_VIEW_X = 2'd0,
		REG_VIEW_Y = 2'd1,
		REG_VIEW_Z = 2'd2
	} reg_index_t;

endpackage

// ===== src/vnr_if.sv =====
// Channel interfaces: pixel normals in, rotated view vectors out.
interface vnr_normal_if #(parameter int W = vnr_pkg::COMPONENT_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] normal_x;
	logic signed [W-1:0] normal_y;
	logic signed [W-1:0] normal_z;
	logic                last_pixel;

	modport source(output valid, output normal_x, output normal_y, output normal_z,
		output last_pixel, input ready);
	modport sink(input valid, input normal_x, input normal_y, input normal_z,
		input last_pixel, output ready);
endinterface

interface vnr_local_if #(parameter int W = vnr_pkg::COMPONENT_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] local_x;
	logic signed [W-1:0] local_y;
	logic signed [W-1:0] local_z;
	logic [1:0]          case_code;
	logic                last_out;

	modport source(output valid, output local_x, output local_y, output local_z,
		output case_code, output last_out, input ready);
	modport sink(input valid, input local_x, input local_y, input local_z,
		input case_code, input last_out, output ready);
endinterface

// ===== src/vnr_front.sv =====
// Front end: accept normals, classify, form sums of squares for the queue.
module vnr_front #(
	parameter int W = vnr_pkg::COMPONENT_WIDTH_DEF,
	localparam int QDW = 4 + 7 * W
) (
	input  logic           clk,
	input  logic           arst_n,
	vnr_normal_if.sink     nrm,
	output logic           push,
	output logic [QDW-1:0] push_data,
	input  logic           q_ready
);

	logic fen;
	logic v_s1, v_s2;

	logic signed [2*W-1:0] sqa_c, sqb_c, sqc_c;
	logic [W-1:0]          ma_c, mb_c, mc_c;

	logic [2*W-1:0] sqa_s1, sqb_s1, sqc_s1;
	logic [W-1:0]   ma_s1, mb_s1, mc_s1;
	logic           face_s1, last_s1, sa_s1, sb_s1;

	logic [2*W-1:0] sbc_s2, srr_s2;
	logic [W-1:0]   ma_s2, mb_s2, mc_s2;
	logic           face_s2, last_s2, sa_s2, sb_s2;

	// Hold both stages while stage two holds a valid item and the queue is full.
	assign fen       = !(v_s2 && !q_ready);
	assign nrm.ready = fen;
	assign push      = v_s2 && q_ready;
	assign push_data = {face_s2, last_s2, sa_s2, sb_s2, ma_s2, mb_s2, mc_s2, sbc_s2, srr_s2};

	always_comb begin
		sqa_c = nrm.normal_x * nrm.normal_x;
		sqb_c = nrm.normal_y * nrm.normal_y;
		sqc_c = nrm.normal_z * nrm.normal_z;
		ma_c  = nrm.normal_x[W-1] ? W'(-nrm.normal_x) : W'(nrm.normal_x);
		mb_c  = nrm.normal_y[W-1] ? W'(-nrm.normal_y) : W'(nrm.normal_y);
		mc_c  = nrm.normal_z[W-1] ? W'(-nrm.normal_z) : W'(nrm.normal_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fen) begin
			v_s1 <= nrm.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			sqa_s1  <= sqa_c;
			sqb_s1  <= sqb_c;
			sqc_s1  <= sqc_c;
			ma_s1   <= ma_c;
			mb_s1   <= mb_c;
			mc_s1   <= mc_c;
			// Normal faces away when z is zero or negative.
			face_s1 <= nrm.normal_z[W-1] || (nrm.normal_z == '0);
			last_s1 <= nrm.last_pixel;
			sa_s1   <= nrm.normal_x[W-1];
			sb_s1   <= nrm.normal_y[W-1];

			sbc_s2  <= sqb_s1 + sqc_s1;
			srr_s2  <= sqa_s1 + sqb_s1 + sqc_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			mc_s2   <= mc_s1;
			face_s2 <= face_s1;
			last_s2 <= last_s1;
			sa_s2   <= sa_s1;
			sb_s2   <= sb_s1;
		end
	end

endmodule

// ===== src/vnr_queue.sv =====
// Short queue decoupling the front end from the rotation back end.
module vnr_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          ready,
	output logic          valid,
	output logic [DW-1:0] rdata,
	input  logic          pop
);

	localparam int DEPTH = vnr_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign ready   = cnt_q != CW'(DEPTH);
	assign valid   = cnt_q != '0;
	assign rdata   = mem_q[rp_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("queue pushed while full");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + CW'($past(do_push)) - CW'($past(do_pop)))
		else $error("queue count out of step with transfers");

endmodule

// ===== src/vnr_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a tag line.
module vnr_sqrt #(
	parameter int W  = vnr_pkg::COMPONENT_WIDTH_DEF,
	parameter int TW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [2*W-1:0] x_i,
	input  logic [TW-1:0]  tag_i,
	output logic           vld_o,
	output logic [W-1:0]   root_o,
	output logic [TW-1:0]  tag_o
);

	logic [W-1:0]   rem_s  [W];
	logic [2*W-1:0] x_s    [W];
	logic [W-1:0]   root_s [W+1];
	logic [TW-1:0]  tag_s  [W+1];
	logic           v_s    [W+1];

	assign rem_s[0]  = '0;
	assign x_s[0]    = x_i;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_i;
	assign v_s[0]    = vld_i;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W+1:0] sh, test, diff;
		logic         ge;

		always_comb begin
			sh   = {rem_s[k], x_s[k][2*W-1 -: 2]};
			test = {root_s[k], 2'b01};
			diff = sh - test;
			ge   = sh >= test;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_s[k][W-2:0], ge};
				tag_s[k+1]  <= tag_s[k];
			end
		end

		if (k < W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[W-1:0] : sh[W-1:0];
					x_s[k+1]   <= x_s[k] << 2;
				end
			end
		end
	end

	assign vld_o  = v_s[W];
	assign root_o = root_s[W];
	assign tag_o  = tag_s[W];

endmodule

// ===== src/vnr_div.sv =====
// Pipelined rounded ratio num/den with FRAC fraction bits, one quotient bit per stage.
module vnr_div #(
	parameter int W  = vnr_pkg::COMPONENT_WIDTH_DEF,
	parameter int TW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic [W-1:0]             num_i,
	input  logic [W-1:0]             den_i,
	input  logic [TW-1:0]            tag_i,
	output logic                     vld_o,
	output logic [vnr_pkg::QUO_W-1:0] q_o,
	output logic [TW-1:0]            tag_o
);

	localparam int FRAC = vnr_pkg::FRAC;
	localparam int QW   = vnr_pkg::QUO_W;
	localparam int NW   = W + QW;

	logic [NW-1:0] n_c;
	logic [W-1:0]  rem_s [QW];
	logic [QW-1:0] nl_s  [QW];
	logic [W-1:0]  den_s [QW];
	logic [QW-1:0] q_s   [QW+1];
	logic [TW-1:0] tag_s [QW+1];
	logic          v_s   [QW+1];

	// Scaled numerator plus half the divisor gives round half away from zero.
	assign n_c    = NW'({num_i, {FRAC{1'b0}}}) + NW'(den_i >> 1);
	assign q_s[0] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_c[NW-1:QW];
			nl_s[0]  <= n_c[QW-1:0];
			den_s[0] <= den_i;
			tag_s[0] <= tag_i;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [W:0] sh, dd, diff;
		logic       ge;

		always_comb begin
			sh   = {rem_s[k], nl_s[k][QW-1]};
			dd   = {1'b0, den_s[k]};
			diff = sh - dd;
			ge   = sh >= dd;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				tag_s[k+1] <= tag_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[W-1:0] : sh[W-1:0];
					nl_s[k+1]  <= nl_s[k] << 1;
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign vld_o = v_s[QW];
	assign q_o   = q_s[QW];
	assign tag_o = tag_s[QW];

endmodule

// ===== src/vnr_back.sv =====
// Back end: norms, ratios, the two rotations, classification and saturation.
module vnr_back #(
	parameter int W = vnr_pkg::COMPONENT_WIDTH_DEF,
	localparam int QDW = 4 + 7 * W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [QDW-1:0]      q_data,
	output logic                pop,
	input  logic signed [W-1:0] view_x,
	input  logic signed [W-1:0] view_y,
	input  logic signed [W-1:0] view_z,
	vnr_local_if.source         loc
);

	localparam int FRAC = vnr_pkg::FRAC;
	localparam int QW   = vnr_pkg::QUO_W;
	localparam int RW   = vnr_pkg::RATIO_W;
	localparam int YW   = W + 2;
	localparam int PW1  = RW + W;
	localparam int SW1  = PW1 + 1;
	localparam int PW2  = RW + YW;
	localparam int SW2  = PW2 + 1;
	localparam int TW1  = 4 + 2 * W;

	localparam logic signed [SW1-1:0] HALF1 =
		{{(SW1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [SW2-1:0] HALF2 =
		{{(SW2-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	function automatic logic signed [W-1:0] sat(input logic signed [YW-1:0] v);
		logic signed [YW-1:0] hi;
		logic signed [YW-1:0] lo;
		hi = YW'(signed'({1'b0, {(W-1){1'b1}}}));
		lo = YW'(signed'({1'b1, {(W-1){1'b0}}}));
		if (v > hi) begin
			return hi[W-1:0];
		end else if (v < lo) begin
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	logic en;

	logic           q_face, q_last, q_sa, q_sb;
	logic [W-1:0]   q_ma, q_mb, q_mc;
	logic [2*W-1:0] q_sbc, q_srr;

	logic           sq1_v, sq2_v, sv;
	logic [W-1:0]   r1, rr;
	logic [TW1-1:0] t1;
	logic           t_face, t_last, t_sa, t_sb;
	logic [W-1:0]   t_ma, t_mb, t_mc;

	logic          dv_cx, dv_sx, dv_cy, dv_sy, dv;
	logic [QW-1:0] qcx, qsx, qcy, qsy;
	logic          d_face, d_sb, d_last, d_sa;

	logic                 v_sg, v_m1, v_a1, v_m2, v_a2, out_v_q;
	logic signed [RW-1:0] cx_sg, sx_sg, cy_sg, sy_sg;
	logic                 face_sg, last_sg;

	logic signed [PW1-1:0] pa_m1, pb_m1, pc_m1, pd_m1;
	logic signed [RW-1:0]  cy_m1, sy_m1;
	logic                  face_m1, last_m1;

	logic signed [SW1-1:0] sum_y, sum_z;
	logic signed [YW-1:0]  yp_a1, zp_a1;
	logic signed [RW-1:0]  cy_a1, sy_a1;
	logic                  face_a1, last_a1;

	logic signed [PW2-1:0] pe_m2, pf_m2, pg_m2, ph_m2;
	logic signed [YW-1:0]  yp_m2;
	logic                  face_m2, last_m2;

	logic signed [SW2-1:0] sum_x, sum_zr;
	logic signed [YW-1:0]  xr_a2, yp_a2, zr_a2;
	logic                  face_a2, last_a2;

	logic signed [W-1:0] lx_q, ly_q, lz_q;
	logic [1:0]          code_q;
	logic                last_q;

	// Advance the whole back end unless a result waits untaken.
	assign en  = !out_v_q || loc.ready;
	assign pop = en && q_valid;

	assign {q_face, q_last, q_sa, q_sb, q_ma, q_mb, q_mc, q_sbc, q_srr} = q_data;

	vnr_sqrt #(.W(W), .TW(TW1)) u_sqrt_bc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (q_valid),
		.x_i    (q_sbc),
		.tag_i  ({q_face, q_last, q_sa, q_sb, q_mb, q_mc}),
		.vld_o  (sq1_v),
		.root_o (r1),
		.tag_o  (t1)
	);

	vnr_sqrt #(.W(W), .TW(W)) u_sqrt_abc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (q_valid),
		.x_i    (q_srr),
		.tag_i  (q_ma),
		.vld_o  (sq2_v),
		.root_o (rr),
		.tag_o  (t_ma)
	);

	assign {t_face, t_last, t_sa, t_sb, t_mb, t_mc} = t1;
	assign sv = sq1_v & sq2_v;

	vnr_div #(.W(W), .TW(1)) u_div_cx (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(sv),
		.num_i(t_mc), .den_i(r1), .tag_i(t_face),
		.vld_o(dv_cx), .q_o(qcx), .tag_o(d_face)
	);

	vnr_div #(.W(W), .TW(1)) u_div_sx (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(sv),
		.num_i(t_mb), .den_i(r1), .tag_i(t_sb),
		.vld_o(dv_sx), .q_o(qsx), .tag_o(d_sb)
	);

	vnr_div #(.W(W), .TW(1)) u_div_cy (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(sv),
		.num_i(r1), .den_i(rr), .tag_i(t_last),
		.vld_o(dv_cy), .q_o(qcy), .tag_o(d_last)
	);

	vnr_div #(.W(W), .TW(1)) u_div_sy (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(sv),
		.num_i(t_ma), .den_i(rr), .tag_i(t_sa),
		.vld_o(dv_sy), .q_o(qsy), .tag_o(d_sa)
	);

	assign dv = dv_cx & dv_sx & dv_cy & dv_sy;

	always_comb begin
		sum_y  = SW1'(pa_m1) - SW1'(pb_m1) + HALF1;
		sum_z  = SW1'(pc_m1) + SW1'(pd_m1) + HALF1;
		sum_x  = SW2'(pe_m2) + SW2'(pf_m2) + HALF2;
		sum_zr = SW2'(pg_m2) - SW2'(ph_m2) + HALF2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sg    <= 1'b0;
			v_m1    <= 1'b0;
			v_a1    <= 1'b0;
			v_m2    <= 1'b0;
			v_a2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_sg    <= dv;
			v_m1    <= v_sg;
			v_a1    <= v_m1;
			v_m2    <= v_a1;
			v_a2    <= v_m2;
			out_v_q <= v_a2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Apply signs: sx follows b, sy follows -a.
			cx_sg   <= signed'({1'b0, qcx});
			sx_sg   <= d_sb ? -signed'({1'b0, qsx}) : signed'({1'b0, qsx});
			cy_sg   <= signed'({1'b0, qcy});
			sy_sg   <= d_sa ? signed'({1'b0, qsy}) : -signed'({1'b0, qsy});
			face_sg <= d_face;
			last_sg <= d_last;

			// Rotation about x.
			pa_m1   <= cx_sg * view_y;
			pb_m1   <= sx_sg * view_z;
			pc_m1   <= sx_sg * view_y;
			pd_m1   <= cx_sg * view_z;
			cy_m1   <= cy_sg;
			sy_m1   <= sy_sg;
			face_m1 <= face_sg;
			last_m1 <= last_sg;

			yp_a1   <= sum_y[FRAC +: YW];
			zp_a1   <= sum_z[FRAC +: YW];
			cy_a1   <= cy_m1;
			sy_a1   <= sy_m1;
			face_a1 <= face_m1;
			last_a1 <= last_m1;

			// Rotation about y.
			pe_m2   <= cy_a1 * view_x;
			pf_m2   <= sy_a1 * zp_a1;
			pg_m2   <= cy_a1 * zp_a1;
			ph_m2   <= sy_a1 * view_x;
			yp_m2   <= yp_a1;
			face_m2 <= face_a1;
			last_m2 <= last_a1;

			xr_a2   <= sum_x[FRAC +: YW];
			zr_a2   <= sum_zr[FRAC +: YW];
			yp_a2   <= yp_m2;
			face_a2 <= face_m2;
			last_a2 <= last_m2;

			last_q <= last_a2;
			if (face_a2) begin
				lx_q   <= '0;
				ly_q   <= '0;
				lz_q   <= '0;
				code_q <= vnr_pkg::CASE_AWAY;
			end else if (zr_a2[YW-1] || zr_a2 == '0) begin
				lx_q   <= '0;
				ly_q   <= '0;
				lz_q   <= '0;
				code_q <= vnr_pkg::CASE_BELOW;
			end else begin
				lx_q   <= sat(xr_a2);
				ly_q   <= sat(yp_a2);
				lz_q   <= sat(zr_a2);
				code_q <= vnr_pkg::CASE_VALID;
			end
		end
	end

	assign loc.valid     = out_v_q;
	assign loc.local_x   = lx_q;
	assign loc.local_y   = ly_q;
	assign loc.local_z   = lz_q;
	assign loc.case_code = code_q;
	assign loc.last_out  = last_q;

	a_valid_above: assert property (@(posedge clk) disable iff (!arst_n)
		loc.valid && loc.case_code == vnr_pkg::CASE_VALID |-> !loc.local_z[W-1]
			&& loc.local_z != '0)
		else $error("valid case with rotated z not above horizon");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		loc.valid && loc.case_code != vnr_pkg::CASE_VALID |-> loc.local_x == '0
			&& loc.local_y == '0 && loc.local_z == '0)
		else $error("rejected pixel with nonzero components");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_a2 |=> loc.valid)
		else $error("finished item lost before the output register");

endmodule

// ===== src/view_to_normal_frame_rotation_top.sv =====
// View-to-normal frame rotation: top level with configuration registers.
//
// Each transfer on normal_ch carries a surface normal (Q2.14 at the default width) and yields
// exactly one transfer on local_ch: the configured view vector rotated into the frame in which
// that normal points along +z, first about x, then about y, with the cosines and sines taken
// as ratios of the normal components and its partial and full norms. A normal with z <= 0
// returns zeros with case_code CASE_AWAY; a rotated view with z <= 0 returns zeros with
// CASE_BELOW; otherwise the saturated components come with CASE_VALID. last_pixel is echoed
// as last_out. The block takes one pixel every clock cycle while the queue has room. An accepted
// input passes through the two front-end stages, the queue, one square-root stage per result bit,
// the divider's input register and one divider stage per quotient bit, the sign stage, then
// the two multiply-and-round rotation steps and the output register. The
// front end keeps taking pixels into a four-entry queue while the output stalls; the back end
// holds in place whenever the output register is full and not taken. Write view_x, view_y and
// view_z (indexes 0 to 2; others are dropped) only while no pixel is in flight. The interface
// instances must use the same width as COMPONENT_WIDTH.
module view_to_normal_frame_rotation_top #(
	parameter int COMPONENT_WIDTH = vnr_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	vnr_normal_if.sink                 normal_ch,
	vnr_local_if.source                local_ch,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [COMPONENT_WIDTH-1:0] cfg_wdata
);

	localparam int W   = COMPONENT_WIDTH;
	localparam int QDW = 4 + 7 * W;

	// View vector registers, reset to straight up (+z of unit length).
	logic signed [W-1:0] view_x_q, view_y_q, view_z_q;

	// Front-to-queue and queue-to-back transfer signals.
	logic           f_push, f_ready;
	logic [QDW-1:0] f_data;
	logic           q_valid, q_pop;
	logic [QDW-1:0] q_data;

	// Configuration write port; out-of-range indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			view_z_q <= {2'b01, {(W-2){1'b0}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				vnr_pkg::REG_VIEW_X: view_x_q <= cfg_wdata;
				vnr_pkg::REG_VIEW_Y: view_y_q <= cfg_wdata;
				vnr_pkg::REG_VIEW_Z: view_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Front end: accept, classify and square the normal components.
	vnr_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.nrm       (normal_ch),
		.push      (f_push),
		.push_data (f_data),
		.q_ready   (f_ready)
	);

	// Decoupling queue: absorbs output stalls so the front end keeps accepting.
	vnr_queue #(.DW(QDW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.ready  (f_ready),
		.valid  (q_valid),
		.rdata  (q_data),
		.pop    (q_pop)
	);

	// Back end: norms, ratios, rotations and the output register.
	vnr_back #(.W(W)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (q_pop),
		.view_x  (view_x_q),
		.view_y  (view_y_q),
		.view_z  (view_z_q),
		.loc     (local_ch)
	);

endmodule

// ===== tb/tb_view_to_normal_frame_rotation_top.sv =====
// Testbench for the view-to-normal frame rotation block: directed and random normals.
`timescale 1ns / 100ps

module tb_view_to_normal_frame_rotation_top;

	localparam int W = vnr_pkg::COMPONENT_WIDTH_DEF;
	localparam int LATENCY = W + 41;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [W-1:0] lx;
		logic signed [W-1:0] ly;
		logic signed [W-1:0] lz;
		vnr_pkg::case_code_t code;
		logic                last;
	} rotated_view_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [W-1:0] cfg_wdata;

	vnr_normal_if #(.W(W)) normal_ch ();
	vnr_local_if #(.W(W)) local_ch ();

	view_to_normal_frame_rotation_top #(.COMPONENT_WIDTH(W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.normal_ch(normal_ch.sink),
		.local_ch(local_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the view registers.
	longint view_x, view_y, view_z;
	rotated_view_t expected_views[$];
	int  error_count = 0;
	longint cycle_count = 0;
	bit  idle_enable = 1;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Bound the run; a hang ends as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout at %0t", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Ratio num/den with FRAC fraction bits, rounded half away from zero.
	function automatic longint trig_ratio(longint num, longint unsigned den);
		longint unsigned m, q;
		m = (num < 0) ? -num : num;
		q = ((m << vnr_pkg::FRAC) + (den >> 1)) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Drop FRAC bits rounding half up; arithmetic shift is a floor.
	function automatic longint round_frac(longint v);
		return (v + (64'sd1 <<< (vnr_pkg::FRAC - 1))) >>> vnr_pkg::FRAC;
	endfunction

	function automatic logic signed [W-1:0] clamp(longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[W-1:0];
	endfunction

	function automatic rotated_view_t rotate_view(logic signed [W-1:0] a_in,
		logic signed [W-1:0] b_in, logic signed [W-1:0] c_in, logic last);
		rotated_view_t res;
		longint a, b, c, cx, sx, cy, sy, yp, zp, xr, zr;
		longint unsigned sbc, r1, r;
		a = a_in;
		b = b_in;
		c = c_in;
		res.lx = '0;
		res.ly = '0;
		res.lz = '0;
		res.last = last;
		res.code = vnr_pkg::CASE_VALID;
		if (c <= 0) begin
			res.code = vnr_pkg::CASE_AWAY;
			return res;
		end
		sbc = b * b + c * c;
		r1 = isqrt(sbc);
		r = isqrt(sbc + a * a);
		cx = trig_ratio(c, r1);
		sx = trig_ratio(b, r1);
		cy = trig_ratio(longint'(r1), r);
		sy = trig_ratio(-a, r);
		yp = round_frac(cx * view_y - sx * view_z);
		zp = round_frac(sx * view_y + cx * view_z);
		xr = round_frac(cy * view_x + sy * zp);
		zr = round_frac(cy * zp - sy * view_x);
		if (zr <= 0) begin
			res.code = vnr_pkg::CASE_BELOW;
		end else begin
			res.lx = clamp(xr);
			res.ly = clamp(yp);
			res.lz = clamp(zr);
		end
		return res;
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// Send one normal; the expectation is queued at the transfer edge.
	task automatic send_normal(logic signed [W-1:0] a, logic signed [W-1:0] b,
		logic signed [W-1:0] c, logic last);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			normal_ch.valid <= 1'b0;
			idle_burst();
		end
		normal_ch.valid <= 1'b1;
		normal_ch.normal_x <= a;
		normal_ch.normal_y <= b;
		normal_ch.normal_z <= c;
		normal_ch.last_pixel <= last;
		@(posedge clk);
		while (!normal_ch.ready)
			@(posedge clk);
		expected_views.push_back(rotate_view(a, b, c, last));
		@(negedge clk);
	endtask

	task automatic drain();
		normal_ch.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_view(vnr_pkg::reg_index_t idx, logic signed [W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vnr_pkg::REG_VIEW_X: view_x = value;
			vnr_pkg::REG_VIEW_Y: view_y = value;
			vnr_pkg::REG_VIEW_Z: view_z = value;
			default: ;
		endcase
	endtask

	task automatic set_view(logic signed [W-1:0] x, logic signed [W-1:0] y,
		logic signed [W-1:0] z);
		write_view(vnr_pkg::REG_VIEW_X, x);
		write_view(vnr_pkg::REG_VIEW_Y, y);
		write_view(vnr_pkg::REG_VIEW_Z, z);
	endtask

	function automatic logic signed [W-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return W'($urandom_range(0, 3)) - W'(1);
			default: return W'($urandom);
		endcase
	endfunction

	// Extremes, facing away, below horizon, at reset view.
	task automatic test_directed();
		logic signed [W-1:0] mx, mn;
		mx = {1'b0, {(W-1){1'b1}}};
		mn = {1'b1, {(W-1){1'b0}}};
		send_normal(0, 0, 16384, 1'b0);
		send_normal(0, 0, 1, 1'b1);
		send_normal(mx, mx, mx, 1'b0);
		send_normal(mn, mn, mx, 1'b1);
		send_normal(mn, mx, 1, 1'b0);
		send_normal(mx, mn, 1, 1'b0);
		send_normal(0, 0, 0, 1'b0);
		send_normal(5, 5, -1, 1'b1);
		send_normal(mx, mx, mn, 1'b0);
		send_normal(1000, -2000, 12000, 1'b1);
		drain();
		// Grazing and negative views to force the below-horizon case and saturation.
		set_view(mx, mn, 16);
		send_normal(16000, 0, 1000, 1'b0);
		send_normal(-16000, 0, 1000, 1'b1);
		send_normal(0, 16000, 1000, 1'b0);
		send_normal(0, -16000, 1000, 1'b0);
		send_normal(0, 0, 16384, 1'b1);
		drain();
		set_view(mn, mx, mn);
		send_normal(0, 0, 16384, 1'b0);
		send_normal(mx, 0, 1, 1'b1);
		send_normal(mn, mx, mx, 1'b0);
		drain();
		set_view(mx, mx, mx);
		send_normal(mx, mx, mx, 1'b1);
		send_normal(mn, mn, 1, 1'b0);
		send_normal(100, -100, 30000, 1'b0);
		drain();
	endtask

	// Random normals in phases with fresh view vectors.
	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_view(rand_comp(), rand_comp(), rand_comp());
			for (int i = 0; i < per_phase; i++)
				send_normal(rand_comp(), rand_comp(), rand_comp(), 1'($urandom));
			drain();
		end
	endtask

	// Sink side: random ready stalls, check each transfer.
	initial begin
		local_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 7) == 0) begin
				local_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				local_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rotated_view_t exp_v;
		if (arst_n && local_ch.valid && local_ch.ready) begin
			if (expected_views.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d code=%0d", $time,
					local_ch.local_x, local_ch.local_y, local_ch.local_z, local_ch.case_code);
				error_count++;
			end else begin
				exp_v = expected_views.pop_front();
				if (local_ch.local_x !== exp_v.lx || local_ch.local_y !== exp_v.ly ||
					local_ch.local_z !== exp_v.lz || local_ch.case_code !== exp_v.code ||
					local_ch.last_out !== exp_v.last) begin
					$display("%0t: expected x=%0d y=%0d z=%0d code=%0d last=%0b", $time,
						exp_v.lx, exp_v.ly, exp_v.lz, exp_v.code, exp_v.last);
					$display("%0t: actual   x=%0d y=%0d z=%0d code=%0d last=%0b", $time,
						local_ch.local_x, local_ch.local_y, local_ch.local_z,
						local_ch.case_code, local_ch.last_out);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = vnr_pkg::REG_VIEW_X;
		cfg_wdata = '0;
		normal_ch.valid = 1'b0;
		normal_ch.normal_x = '0;
		normal_ch.normal_y = '0;
		normal_ch.normal_z = '0;
		normal_ch.last_pixel = 1'b0;
		view_x = 0;
		view_y = 0;
		view_z = 64'sd1 <<< (W - 2);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(10, 50);
		// Final stretch: no idling on either side.
		idle_enable = 0;
		test_random(1, 25);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
